/* sv/spll_pkg.sv */
// ----------------------------------------------------------------------------
// spll_pkg
// Shared constants and types for the slot pool linked list block.
// ----------------------------------------------------------------------------
package spll_pkg;

	// pool geometry
	localparam int SLOTS    = 32;
	localparam int SLOT_W   = $clog2(SLOTS);
	localparam int LINK_W   = SLOT_W + 1;
	localparam int CNT_W    = $clog2(SLOTS + 1);
	localparam int CAP_W    = 6;
	localparam int DATA_W   = 8;
	localparam int CMD_W    = 3;
	localparam int STATUS_W = 2;

	// link code for end of list
	localparam logic [LINK_W-1:0] LINK_END = LINK_W'(SLOTS);

	// command codes
	localparam logic [CMD_W-1:0] CMD_INS_HEAD  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INS_TAIL  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INS_AFTER = 3'd2;
	localparam logic [CMD_W-1:0] CMD_REM_HEAD  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_REM_TAIL  = 3'd4;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_EMPTY     = 2'd2,
		STAT_NO_ANCHOR = 2'd3
	} status_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_ANCHOR,
		S_FIX,
		S_RDHEAD,
		S_RDTAIL,
		S_WALK,
		S_FIN
	} state_t;

endpackage

/* sv/spll_ram.sv */
// ----------------------------------------------------------------------------
// spll_ram
// Simple dual port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module spll_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/slot_pool_linked_list_top.sv */
// ----------------------------------------------------------------------------
// slot_pool_linked_list_top
// Singly linked list of bytes kept in a fixed pool of slots.
// ----------------------------------------------------------------------------
// One item is handled at a time: in_ready is high only while the sequencer is
// idle. Inserts first run the free slot scan (lowest free slot first), then
// link the new node in. Remove tail walks the list from the head through the
// link RAM, one node per cycle, to find the new tail; a single node needs no
// walk. The result sits in an output register, so a new item can be accepted
// while a result waits to be taken.
// The capacity register may be written at any time the block is idle; values
// above the pool size act as the pool size. No clearing pass is needed after
// reset: slot occupancy is held in flip-flops that reset clears at once.
// ----------------------------------------------------------------------------
module slot_pool_linked_list_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [spll_pkg::CAP_W-1:0]    cfg_data,
	// command items
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [spll_pkg::CMD_W-1:0]    cmd,
	input  logic [spll_pkg::DATA_W-1:0]   data_in,
	input  logic [spll_pkg::SLOT_W-1:0]   after_slot,
	// result items
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [spll_pkg::STATUS_W-1:0] status,
	output logic [spll_pkg::SLOT_W-1:0]   slot,
	output logic [spll_pkg::DATA_W-1:0]   data_out,
	output logic [spll_pkg::CAP_W-1:0]    free_space
);
	import spll_pkg::*;

	state_t              state_q, state_d;
	logic [CAP_W-1:0]    cap_q;
	logic [CNT_W-1:0]    cap_eff;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [LINK_W-1:0]   head_q, head_d;
	logic [LINK_W-1:0]   tail_q, tail_d;
	logic [SLOTS-1:0]    used_q;
	logic                used_set, used_clr;

	logic [CMD_W-1:0]    cmd_q;
	logic [DATA_W-1:0]   din_q;
	logic [SLOT_W-1:0]   anchor_q;
	logic [SLOT_W-1:0]   n_q, n_d;
	logic [SLOT_W-1:0]   p_q, p_d;
	logic [CNT_W-1:0]    idx_q, idx_d;
	status_t             res_status_q, res_status_d;
	logic [SLOT_W-1:0]   res_slot_q, res_slot_d;
	logic [DATA_W-1:0]   res_data_q, res_data_d;

	logic                out_valid_q;
	logic                out_load;
	status_t             status_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [DATA_W-1:0]   data_out_q;
	logic [CAP_W-1:0]    free_space_q;
	logic [CNT_W-1:0]    fs_now;

	logic                lk_we, lk_re;
	logic [SLOT_W-1:0]   lk_waddr, lk_raddr;
	logic [LINK_W-1:0]   lk_wdata, lk_rdata;
	logic                dt_we, dt_re;
	logic [SLOT_W-1:0]   dt_raddr;
	logic [DATA_W-1:0]   dt_rdata;

	// memories: next links and data bytes
	spll_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_link_ram (
		.clk   (clk),
		.we    (lk_we),
		.waddr (lk_waddr),
		.wdata (lk_wdata),
		.re    (lk_re),
		.raddr (lk_raddr),
		.rdata (lk_rdata)
	);

	spll_ram #(.WIDTH(DATA_W), .DEPTH(SLOTS)) u_data_ram (
		.clk   (clk),
		.we    (dt_we),
		.waddr (idx_q[SLOT_W-1:0]),
		.wdata (din_q),
		.re    (dt_re),
		.raddr (dt_raddr),
		.rdata (dt_rdata)
	);

	// effective capacity and free space
	assign cap_eff = (CNT_W'(cap_q) > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : CNT_W'(cap_q);
	assign fs_now  = (count_q >= cap_eff) ? '0 : cap_eff - count_q;

	assign cfg_ready  = 1'b1;
	assign in_ready   = (state_q == S_IDLE);
	assign out_load   = (state_q == S_FIN) && (!out_valid_q || out_ready);
	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign slot       = slot_q;
	assign data_out   = data_out_q;
	assign free_space = free_space_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state and datapath control
	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		head_d       = head_q;
		tail_d       = tail_q;
		n_d          = n_q;
		p_d          = p_q;
		idx_d        = idx_q;
		res_status_d = res_status_q;
		res_slot_d   = res_slot_q;
		res_data_d   = res_data_q;
		used_set     = 1'b0;
		used_clr     = 1'b0;
		lk_we        = 1'b0;
		lk_waddr     = n_q;
		lk_wdata     = LINK_END;
		lk_re        = 1'b0;
		lk_raddr     = head_q[SLOT_W-1:0];
		dt_we        = 1'b0;
		dt_re        = 1'b0;
		dt_raddr     = head_q[SLOT_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				res_status_d = STAT_OK;
				res_slot_d   = '0;
				res_data_d   = '0;
				idx_d        = '0;
				if (in_valid) begin
					priority if (cmd <= CMD_INS_AFTER) begin
						priority if (count_q >= cap_eff) begin
							res_status_d = STAT_FULL;
							state_d      = S_FIN;
						end else if (cmd == CMD_INS_AFTER && count_q != '0 &&
								!used_q[after_slot]) begin
							res_status_d = STAT_NO_ANCHOR;
							state_d      = S_FIN;
						end else begin
							state_d = S_SCAN;
						end
					end else if (cmd == CMD_REM_HEAD) begin
						if (count_q == '0) begin
							res_status_d = STAT_EMPTY;
							state_d      = S_FIN;
						end else begin
							n_d      = head_q[SLOT_W-1:0];
							lk_re    = 1'b1;
							lk_raddr = head_q[SLOT_W-1:0];
							dt_re    = 1'b1;
							dt_raddr = head_q[SLOT_W-1:0];
							state_d  = S_RDHEAD;
						end
					end else if (cmd == CMD_REM_TAIL) begin
						if (count_q == '0) begin
							res_status_d = STAT_EMPTY;
							state_d      = S_FIN;
						end else begin
							n_d      = tail_q[SLOT_W-1:0];
							dt_re    = 1'b1;
							dt_raddr = tail_q[SLOT_W-1:0];
							if (head_q == tail_q || count_q == CNT_W'(1)) begin
								state_d = S_RDTAIL;
							end else begin
								p_d      = head_q[SLOT_W-1:0];
								lk_re    = 1'b1;
								lk_raddr = head_q[SLOT_W-1:0];
								state_d  = S_WALK;
							end
						end
					end else begin
						state_d = S_FIN;
					end
				end
			end
			// lowest free slot search, one slot a cycle
			S_SCAN: begin
				priority if (idx_q >= cap_eff) begin
					res_status_d = STAT_FULL;
					state_d      = S_FIN;
				end else if (!used_q[idx_q[SLOT_W-1:0]]) begin
					n_d        = idx_q[SLOT_W-1:0];
					dt_we      = 1'b1;
					used_set   = 1'b1;
					count_d    = count_q + CNT_W'(1);
					res_slot_d = idx_q[SLOT_W-1:0];
					lk_waddr   = idx_q[SLOT_W-1:0];
					priority if (count_q == '0) begin
						lk_we    = 1'b1;
						lk_wdata = LINK_END;
						head_d   = LINK_W'(idx_q);
						tail_d   = LINK_W'(idx_q);
						state_d  = S_FIN;
					end else if (cmd_q == CMD_INS_HEAD) begin
						lk_we    = 1'b1;
						lk_wdata = head_q;
						head_d   = LINK_W'(idx_q);
						state_d  = S_FIN;
					end else if (cmd_q == CMD_INS_TAIL) begin
						lk_we    = 1'b1;
						lk_wdata = LINK_END;
						p_d      = tail_q[SLOT_W-1:0];
						tail_d   = LINK_W'(idx_q);
						state_d  = S_FIX;
					end else begin
						lk_re    = 1'b1;
						lk_raddr = anchor_q;
						state_d  = S_ANCHOR;
					end
				end else begin
					idx_d = idx_q + CNT_W'(1);
				end
			end
			// new node takes over the anchor's successor
			S_ANCHOR: begin
				lk_we    = 1'b1;
				lk_waddr = n_q;
				lk_wdata = lk_rdata;
				p_d      = anchor_q;
				if (tail_q == LINK_W'(anchor_q)) begin
					tail_d = LINK_W'(n_q);
				end
				state_d = S_FIX;
			end
			// predecessor now points at the new node
			S_FIX: begin
				lk_we    = 1'b1;
				lk_waddr = p_q;
				lk_wdata = LINK_W'(n_q);
				state_d  = S_FIN;
			end
			S_RDHEAD: begin
				used_clr   = 1'b1;
				count_d    = count_q - CNT_W'(1);
				res_slot_d = n_q;
				res_data_d = dt_rdata;
				if (count_q == CNT_W'(1) || lk_rdata >= LINK_END) begin
					head_d = LINK_END;
					tail_d = LINK_END;
				end else begin
					head_d = lk_rdata;
				end
				state_d = S_FIN;
			end
			S_RDTAIL: begin
				used_clr   = 1'b1;
				count_d    = count_q - CNT_W'(1);
				res_slot_d = n_q;
				res_data_d = dt_rdata;
				head_d     = LINK_END;
				tail_d     = LINK_END;
				state_d    = S_FIN;
			end
			// walk from the head to the node before the tail
			S_WALK: begin
				res_data_d = dt_rdata;
				priority if (lk_rdata == LINK_W'(n_q)) begin
					lk_we      = 1'b1;
					lk_waddr   = p_q;
					lk_wdata   = LINK_END;
					tail_d     = LINK_W'(p_q);
					used_clr   = 1'b1;
					count_d    = count_q - CNT_W'(1);
					res_slot_d = n_q;
					state_d    = S_FIN;
				end else if (lk_rdata >= LINK_END || idx_q >= CNT_W'(SLOTS)) begin
					tail_d     = LINK_END;
					used_clr   = 1'b1;
					count_d    = count_q - CNT_W'(1);
					res_slot_d = n_q;
					state_d    = S_FIN;
				end else begin
					p_d      = lk_rdata[SLOT_W-1:0];
					lk_re    = 1'b1;
					lk_raddr = lk_rdata[SLOT_W-1:0];
					idx_d    = idx_q + CNT_W'(1);
				end
			end
			S_FIN: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// list control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_W'(32);
			count_q <= '0;
			head_q  <= LINK_END;
			tail_q  <= LINK_END;
			used_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			count_q <= count_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			if (used_set) begin
				used_q[idx_q[SLOT_W-1:0]] <= 1'b1;
			end
			if (used_clr) begin
				used_q[n_q] <= 1'b0;
			end
		end
	end

	// working registers of the current item
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q    <= cmd;
			din_q    <= data_in;
			anchor_q <= after_slot;
		end
		n_q          <= n_d;
		p_q          <= p_d;
		idx_q        <= idx_d;
		res_status_q <= res_status_d;
		res_slot_q   <= res_slot_d;
		res_data_q   <= res_data_d;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q     <= res_status_q;
			slot_q       <= res_slot_q;
			data_out_q   <= res_data_q;
			free_space_q <= CAP_W'(fs_now);
		end
	end

	// occupancy bits always agree with the element count
	a_used_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(used_q) == int'(count_q))
		else $error("occupancy bits disagree with element count");

	// an empty list has no head and no tail, a non-empty one has both
	a_head_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) == (head_q == LINK_END))
		else $error("head marker inconsistent with element count");

	a_tail_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) == (tail_q == LINK_END))
		else $error("tail marker inconsistent with element count");

	// a successful insert reports a slot that is now occupied
	a_insert_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && res_status_q == STAT_OK && cmd_q <= CMD_INS_AFTER)
		|-> used_q[res_slot_q])
		else $error("insert reported a slot that is not occupied");

	// an accepted item blocks further items while it is worked on
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("new item accepted while busy");

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the slot pool linked list: a directed table of
// commands and capacity writes, then random command streams over several
// capacities, checked item by item against a behavioral model or typed rows.
// ----------------------------------------------------------------------------
module tb_top;

	import spll_pkg::*;

	// run limits
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 40;
	localparam int LONG_HOLD   = 300;
	localparam int DIR_ROWS    = 25;
	localparam int PHASES      = 8;

	// command codes the block does not decode
	localparam logic [CMD_W-1:0] CMD_RSVD_5 = 3'd5;
	localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

	// link code for a slot not in the list
	localparam logic [LINK_W-1:0] LINK_FREE_C = LINK_W'(SLOTS + 1);

	typedef struct packed {
		status_t               st;
		logic [SLOT_W-1:0]     slot;
		logic [DATA_W-1:0]     dout;
		logic [CAP_W-1:0]      fs;
	} list_result_t;

	typedef enum logic [1:0] {
		ROW_ITEM,
		ROW_TYPED,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CAP_W-1:0]      cap;
		logic [CMD_W-1:0]      op;
		logic [DATA_W-1:0]     din;
		logic [SLOT_W-1:0]     anchor;
		status_t               st;
		logic [SLOT_W-1:0]     slot;
		logic [DATA_W-1:0]     dout;
		logic [CAP_W-1:0]      fs;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CAP_W-1:0]      cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [CMD_W-1:0]      cmd;
	logic [DATA_W-1:0]     data_in;
	logic [SLOT_W-1:0]     after_slot;
	logic                  out_valid;
	logic                  out_ready;
	logic [STATUS_W-1:0]   status;
	logic [SLOT_W-1:0]     slot;
	logic [DATA_W-1:0]     data_out;
	logic [CAP_W-1:0]      free_space;

	// list model state
	logic [DATA_W-1:0]     pool_data [SLOTS];
	logic [LINK_W-1:0]     pool_link [SLOTS];
	int                    list_head;
	int                    list_tail;
	int                    list_len;
	logic [CAP_W-1:0]      cap_reg;

	list_result_t          pending_results [$];
	int                    error_count;
	int                    results_seen;
	int                    cycle_count;
	bit                    idle_on;

	// directed commands; typed rows carry results that are plain at a glance
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{ROW_TYPED, 6'd0,  CMD_REM_HEAD,  8'h00, 5'd0,  STAT_EMPTY,     5'd0, 8'h00, 6'd32},
		'{ROW_TYPED, 6'd0,  CMD_REM_TAIL,  8'h00, 5'd0,  STAT_EMPTY,     5'd0, 8'h00, 6'd32},
		'{ROW_TYPED, 6'd0,  CMD_INS_AFTER, 8'hFF, 5'd31, STAT_OK,        5'd0, 8'h00, 6'd31},
		'{ROW_TYPED, 6'd0,  CMD_INS_AFTER, 8'h00, 5'd5,  STAT_NO_ANCHOR, 5'd0, 8'h00, 6'd31},
		'{ROW_ITEM,  6'd0,  CMD_INS_HEAD,  8'h00, 5'd0,  STAT_OK,        5'd0, 8'h00, 6'd0},
		'{ROW_ITEM,  6'd0,  CMD_INS_TAIL,  8'hA5, 5'd0,  STAT_OK,        5'd0, 8'h00, 6'd0},
		'{ROW_ITEM,  6'd0,  CMD_INS_AFTER, 8'h5A, 5'd0,  STAT_OK,        5'd0, 8'h00, 6'd0},
		'{ROW_ITEM,  6'd0,  CMD_RSVD_7,    8'hFF, 5'd31, STAT_OK,        5'd0, 8'h00, 6'd0},
		'{ROW_ITEM,  6'd0,  CMD_RSVD_5,    8'h55, 5'd10, STAT_OK,        5'd0, 8'h00, 6'd0},
		'{ROW_ITEM,  6'd0,  CMD_RSVD_6,    8'hAA, 5'd21, STAT_OK,        5'd0, 8'h00, 6'd0},
		'{ROW_ITEM,  6'd0,  CMD_REM_TAIL,  8'h00, 5'd0,  STAT_OK,        5'd0, 8'h00, 6'd0},
		'{ROW_ITEM,  6'd0,  CMD_REM_HEAD,  8'h00, 5'd0,  STAT_OK,        5'd0, 8'h00, 6'd0},
		'{ROW_CFG,   6'd2,  CMD_INS_HEAD,  8'h00, 5'd0,  STAT_OK,        5'd0, 8'h00, 6'd0},
		'{ROW_ITEM,  6'd0,  CMD_INS_TAIL,  8'h01, 5'd0,  STAT_OK,        5'd0, 8'h00, 6'd0},
		'{ROW_ITEM,  6'd0,  CMD_INS_HEAD,  8'h80, 5'd0,  STAT_OK,        5'd0, 8'h00, 6'd0},
		'{ROW_ITEM,  6'd0,  CMD_INS_AFTER, 8'h7F, 5'd31, STAT_OK,        5'd0, 8'h00, 6'd0},
		'{ROW_CFG,   6'd0,  CMD_INS_HEAD,  8'h00, 5'd0,  STAT_OK,        5'd0, 8'h00, 6'd0},
		'{ROW_TYPED, 6'd0,  CMD_INS_TAIL,  8'h33, 5'd0,  STAT_FULL,      5'd0, 8'h00, 6'd0},
		'{ROW_ITEM,  6'd0,  CMD_REM_HEAD,  8'h00, 5'd0,  STAT_OK,        5'd0, 8'h00, 6'd0},
		'{ROW_ITEM,  6'd0,  CMD_REM_TAIL,  8'h00, 5'd0,  STAT_OK,        5'd0, 8'h00, 6'd0},
		'{ROW_ITEM,  6'd0,  CMD_REM_TAIL,  8'h00, 5'd0,  STAT_OK,        5'd0, 8'h00, 6'd0},
		'{ROW_ITEM,  6'd0,  CMD_REM_HEAD,  8'h00, 5'd0,  STAT_OK,        5'd0, 8'h00, 6'd0},
		'{ROW_CFG,   6'd63, CMD_INS_HEAD,  8'h00, 5'd0,  STAT_OK,        5'd0, 8'h00, 6'd0},
		'{ROW_ITEM,  6'd0,  CMD_INS_HEAD,  8'hFF, 5'd31, STAT_OK,        5'd0, 8'h00, 6'd0},
		'{ROW_ITEM,  6'd0,  CMD_INS_AFTER, 8'h00, 5'd0,  STAT_OK,        5'd0, 8'h00, 6'd0}
	};

	// random phases: capacity and item count, a negative capacity means pick one
	int phase_cap   [PHASES] = '{32, 1, 5, 0, 63, 17, -1, 32};
	int phase_items [PHASES] = '{110, 40, 80, 20, 110, 90, 100, 100};

	slot_pool_linked_list_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.data_in    (data_in),
		.after_slot (after_slot),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.slot       (slot),
		.data_out   (data_out),
		.free_space (free_space)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// apply one command to the list model and return its result
	function automatic list_result_t predict_list_op(input logic [CMD_W-1:0] op,
			input logic [DATA_W-1:0] din, input logic [SLOT_W-1:0] anchor);
		list_result_t r;
		int cap, n, p, k, i;
		bit anchor_ok;
		r.st   = STAT_OK;
		r.slot = '0;
		r.dout = '0;
		r.fs   = '0;
		cap = (int'(cap_reg) > SLOTS) ? SLOTS : int'(cap_reg);
		// lowest free slot below the capacity
		n = SLOTS;
		for (i = cap - 1; i >= 0; i--)
			if (pool_link[i] == LINK_FREE_C)
				n = i;
		anchor_ok = (pool_link[anchor] != LINK_FREE_C);
		case (op)
			CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AFTER: begin
				if (list_len >= cap) begin
					r.st = STAT_FULL;
				end else if (op == CMD_INS_AFTER && list_len != 0 && !anchor_ok) begin
					r.st = STAT_NO_ANCHOR;
				end else if (n == SLOTS) begin
					r.st = STAT_FULL;
				end else begin
					pool_data[n] = din;
					if (list_len == 0 || list_head >= SLOTS || list_tail >= SLOTS) begin
						pool_link[n] = LINK_END;
						list_head = n;
						list_tail = n;
					end else if (op == CMD_INS_HEAD) begin
						pool_link[n] = LINK_W'(list_head);
						list_head = n;
					end else if (op == CMD_INS_TAIL) begin
						pool_link[n] = LINK_END;
						pool_link[list_tail] = LINK_W'(n);
						list_tail = n;
					end else begin
						pool_link[n] = pool_link[anchor];
						pool_link[anchor] = LINK_W'(n);
						if (list_tail == int'(anchor))
							list_tail = n;
					end
					list_len++;
					r.slot = SLOT_W'(n);
				end
			end
			CMD_REM_HEAD: begin
				if (list_len == 0 || list_head >= SLOTS) begin
					r.st = STAT_EMPTY;
				end else begin
					n = list_head;
					r.dout = pool_data[n];
					list_head = int'(pool_link[n]);
					pool_link[n] = LINK_FREE_C;
					list_len--;
					if (list_len == 0 || list_head >= SLOTS) begin
						list_head = SLOTS;
						list_tail = SLOTS;
					end
					r.slot = SLOT_W'(n);
				end
			end
			CMD_REM_TAIL: begin
				if (list_len == 0 || list_tail >= SLOTS) begin
					r.st = STAT_EMPTY;
				end else begin
					n = list_tail;
					r.dout = pool_data[n];
					if (list_head == n || list_len == 1) begin
						list_head = SLOTS;
						list_tail = SLOTS;
					end else begin
						// walk from the head to the node before the tail
						p = list_head;
						k = 0;
						while (p < SLOTS && int'(pool_link[p]) != n && k < SLOTS) begin
							p = int'(pool_link[p]);
							k++;
						end
						if (p < SLOTS && int'(pool_link[p]) == n) begin
							pool_link[p] = LINK_END;
							list_tail = p;
						end else begin
							list_tail = SLOTS;
						end
					end
					pool_link[n] = LINK_FREE_C;
					list_len--;
					r.slot = SLOT_W'(n);
				end
			end
			default: ;
		endcase
		r.fs = (list_len >= cap) ? '0 : CAP_W'(cap - list_len);
		return r;
	endfunction

	// one line per mismatch
	task automatic report_mismatch(input string msg);
		$display("mismatch at result %0d: %s", results_seen, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	// result checker
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result item with nothing expected");
			end else begin
				want = pending_results.pop_front();
				check_field("status", status, want.st);
				check_field("slot", slot, want.slot);
				check_field("data_out", data_out, want.dout);
				check_field("free_space", free_space, want.fs);
			end
			results_seen++;
		end
	end

	// receiver: random stalls plus one long hold-off to back up the block
	initial begin
		int stall_left;
		bit long_done;
		stall_left = 0;
		long_done  = 1'b0;
		out_ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!long_done && results_seen >= 100) begin
				long_done  = 1'b1;
				stall_left = LONG_HOLD - 1;
				out_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 13) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// offer one command item, predict it on acceptance; ends at a falling edge
	task automatic offer_item(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] din,
			input logic [SLOT_W-1:0] anc, input bit typed, input list_result_t typed_res);
		list_result_t pred;
		int gap;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 13);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= op;
		data_in    <= din;
		after_slot <= anc;
		do @(posedge clk); while (!in_ready);
		pred = predict_list_op(op, din, anc);
		pending_results.push_back(typed ? typed_res : pred);
		@(negedge clk);
	endtask

	// capacity write once every result is out; called at a falling edge
	task automatic write_capacity(input logic [CAP_W-1:0] value);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cap_reg = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// stimulus
	initial begin
		list_result_t typed_res;
		logic [CMD_W-1:0] op;
		logic [DATA_W-1:0] din;
		logic [SLOT_W-1:0] anc;
		int i, j, ph, r, p, steps, capv;
		bit fill_mode;

		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		in_valid   = 1'b0;
		cmd        = '0;
		data_in    = '0;
		after_slot = '0;
		idle_on    = 1'b1;
		fill_mode  = 1'b1;
		error_count  = 0;
		results_seen = 0;

		// model reset
		for (i = 0; i < SLOTS; i++) begin
			pool_data[i] = '0;
			pool_link[i] = LINK_FREE_C;
		end
		list_head = SLOTS;
		list_tail = SLOTS;
		list_len  = 0;
		cap_reg   = CAP_W'(32);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table
		for (i = 0; i < DIR_ROWS; i++) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				write_capacity(dir_rows[i].cap);
			end else begin
				typed_res.st   = dir_rows[i].st;
				typed_res.slot = dir_rows[i].slot;
				typed_res.dout = dir_rows[i].dout;
				typed_res.fs   = dir_rows[i].fs;
				offer_item(dir_rows[i].op, dir_rows[i].din, dir_rows[i].anchor,
					dir_rows[i].kind == ROW_TYPED, typed_res);
			end
		end

		// random phases, the last one with no idling
		for (ph = 0; ph < PHASES; ph++) begin
			capv = (phase_cap[ph] < 0) ? $urandom_range(1, 32) : phase_cap[ph];
			write_capacity(CAP_W'(capv));
			if (ph == PHASES - 1)
				idle_on = 1'b0;
			for (j = 0; j < phase_items[ph]; j++) begin
				if ($urandom_range(0, 24) == 0)
					fill_mode = !fill_mode;
				r = $urandom_range(0, 99);
				if (r < 4)
					op = CMD_W'($urandom_range(5, 7));
				else if (fill_mode)
					op = (r < 35) ? CMD_INS_HEAD : (r < 60) ? CMD_INS_TAIL :
						(r < 82) ? CMD_INS_AFTER : (r < 91) ? CMD_REM_HEAD : CMD_REM_TAIL;
				else
					op = (r < 15) ? CMD_INS_HEAD : (r < 25) ? CMD_INS_TAIL :
						(r < 35) ? CMD_INS_AFTER : (r < 67) ? CMD_REM_HEAD : CMD_REM_TAIL;
				din = DATA_W'($urandom);
				// anchor mostly a list member, found by walking from the head
				if (list_len > 0 && $urandom_range(0, 99) < 80) begin
					p = list_head;
					steps = $urandom_range(0, list_len - 1);
					for (i = 0; i < steps && p < SLOTS; i++)
						p = int'(pool_link[p]);
					anc = (p < SLOTS) ? SLOT_W'(p) : SLOT_W'($urandom_range(0, 31));
				end else begin
					anc = SLOT_W'($urandom_range(0, 31));
				end
				offer_item(op, din, anc, 1'b0, typed_res);
			end
		end

		// drain
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* slot_pool_linked_list_top.f */
sv/spll_pkg.sv
sv/spll_ram.sv
sv/slot_pool_linked_list_top.sv
verif/tb_top.sv
